@@ rtl/kdea_pkg.sv @@
`timescale 1ns / 1ps
package kdea_pkg;

	localparam int SUM_W           = 32;
	localparam int MUL_W           = 64;
	localparam int RATIO_W         = 32;
	localparam int FRAC_BITS       = 16;
	localparam int ENT_W           = 16;
	localparam int NUM_SHIFT       = 22;
	localparam int DEN_SHIFT       = 44;
	localparam int DIV_STEPS       = 32;
	localparam int CNT_W           = $clog2(DIV_STEPS);
	localparam int SHIFT_W         = $clog2(RATIO_W);
	localparam int MAX_SAMPLES_DEF = 256;
	localparam int INPUT_BITS_DEF  = 24;

	typedef enum logic [2:0] {
		ST_ACCUM,
		ST_PROD,
		ST_SETUP,
		ST_DIV,
		ST_NORM,
		ST_SQR,
		ST_FOLD,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic do_prod;
		logic do_setup;
		logic do_div;
		logic do_norm;
		logic do_sqr;
		logic do_fold;
		logic load_out;
	} ctrl_t;

	typedef struct packed {
		logic none;
		logic sat;
		logic m_top;
		logic m_zero;
	} status_t;

endpackage

@@ rtl/kdea_accum.sv @@
`timescale 1ns / 1ps
module kdea_accum #(
	parameter int MAX_SAMPLES = kdea_pkg::MAX_SAMPLES_DEF,
	parameter int INPUT_BITS  = kdea_pkg::INPUT_BITS_DEF,
	parameter int TALLY_W     = $clog2(MAX_SAMPLES + 1)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          acc_en,
	input  logic                          clr,
	input  logic signed [INPUT_BITS-1:0]  kernel_value,
	input  logic signed [INPUT_BITS-1:0]  first_weight,
	input  logic signed [INPUT_BITS-1:0]  second_weight,
	input  logic                          sample_valid,
	output logic [kdea_pkg::SUM_W-1:0]    kernel_total,
	output logic [kdea_pkg::SUM_W-1:0]    weight_one_total,
	output logic [kdea_pkg::SUM_W-1:0]    weight_two_total,
	output logic [TALLY_W-1:0]            sample_tally
);
	import kdea_pkg::*;

	logic [SUM_W-1:0]   kernel_total_q, weight_one_total_q, weight_two_total_q;
	logic [TALLY_W-1:0] sample_tally_q;
	logic               take;

	// samples past the cap are dropped until the sums clear
	assign take = acc_en && sample_valid && (sample_tally_q < TALLY_W'(MAX_SAMPLES));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kernel_total_q     <= '0;
			weight_one_total_q <= '0;
			weight_two_total_q <= '0;
			sample_tally_q     <= '0;
		end else if (clr) begin
			kernel_total_q     <= '0;
			weight_one_total_q <= '0;
			weight_two_total_q <= '0;
			sample_tally_q     <= '0;
		end else if (take) begin
			kernel_total_q     <= kernel_total_q + SUM_W'(kernel_value);
			weight_one_total_q <= weight_one_total_q + SUM_W'(first_weight);
			weight_two_total_q <= weight_two_total_q + SUM_W'(second_weight);
			sample_tally_q     <= sample_tally_q + TALLY_W'(1);
		end
	end

	assign kernel_total     = kernel_total_q;
	assign weight_one_total = weight_one_total_q;
	assign weight_two_total = weight_two_total_q;
	assign sample_tally     = sample_tally_q;

endmodule

@@ rtl/kdea_seq.sv @@
`timescale 1ns / 1ps
module kdea_seq (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              last,
	input  logic              out_busy,
	input  kdea_pkg::status_t status,
	output logic              in_ready,
	output kdea_pkg::ctrl_t   ctrl
);
	import kdea_pkg::*;

	state_t           state_q, state_nxt;
	logic [CNT_W-1:0] cnt_q;

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_ACCUM: begin
				if (in_valid && last) state_nxt = ST_PROD;
			end
			ST_PROD: state_nxt = ST_SETUP;
			ST_SETUP: begin
				if (status.none)     state_nxt = ST_FINISH;
				else if (status.sat) state_nxt = ST_NORM;
				else                 state_nxt = ST_DIV;
			end
			ST_DIV: begin
				if (cnt_q == CNT_W'(DIV_STEPS - 1)) state_nxt = ST_NORM;
			end
			ST_NORM: begin
				if (status.m_zero)     state_nxt = ST_FINISH;
				else if (status.m_top) state_nxt = ST_SQR;
			end
			ST_SQR: state_nxt = ST_FOLD;
			ST_FOLD: begin
				if (cnt_q == CNT_W'(FRAC_BITS - 1)) state_nxt = ST_FINISH;
				else                                state_nxt = ST_SQR;
			end
			ST_FINISH: begin
				if (!out_busy) state_nxt = ST_ACCUM;
			end
			default: state_nxt = ST_ACCUM;
		endcase
	end

	always_comb begin
		ctrl     = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_ACCUM:  in_ready      = 1'b1;
			ST_PROD:   ctrl.do_prod  = 1'b1;
			ST_SETUP:  ctrl.do_setup = 1'b1;
			ST_DIV:    ctrl.do_div   = 1'b1;
			ST_NORM:   ctrl.do_norm  = 1'b1;
			ST_SQR:    ctrl.do_sqr   = 1'b1;
			ST_FOLD:   ctrl.do_fold  = 1'b1;
			ST_FINISH: ctrl.load_out = !out_busy;
			default:   in_ready      = 1'b0;
		endcase
	end

	// step count: divide bits, then fold steps (held across the square cycle)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_ACCUM;
			cnt_q   <= '0;
		end else begin
			state_q <= state_nxt;
			if (state_q == ST_DIV || state_q == ST_FOLD) cnt_q <= cnt_q + CNT_W'(1);
			else if (state_q != ST_SQR)                  cnt_q <= '0;
		end
	end

endmodule

@@ rtl/kdea_dpath.sv @@
`timescale 1ns / 1ps
module kdea_dpath #(
	parameter int MAX_SAMPLES = kdea_pkg::MAX_SAMPLES_DEF,
	parameter int TALLY_W     = $clog2(MAX_SAMPLES + 1)
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  kdea_pkg::ctrl_t             ctrl,
	input  logic [kdea_pkg::SUM_W-1:0]  kernel_total,
	input  logic [kdea_pkg::SUM_W-1:0]  weight_one_total,
	input  logic [kdea_pkg::SUM_W-1:0]  weight_two_total,
	input  logic [TALLY_W-1:0]          sample_tally,
	input  logic                        out_ready,
	output kdea_pkg::status_t           status,
	output logic                        out_busy,
	output logic                        out_valid,
	output logic [kdea_pkg::ENT_W-1:0]  entropy_value,
	output logic                        ratio_zero,
	output logic                        no_samples
);
	import kdea_pkg::*;

	// shared multiplier: weight product, then mantissa squares
	logic signed [SUM_W:0]     mul_a, mul_b;
	logic signed [2*SUM_W+1:0] mul_full;
	logic [MUL_W-1:0]          mul_q;

	logic [MUL_W-1:0]   rem_q, den_q;
	logic [RATIO_W-1:0] m_q;
	logic [SHIFT_W-1:0] s_q;
	logic [FRAC_BITS-1:0] f_q;
	logic               err_q, none_q;

	logic [SUM_W-1:0]   k_pos;
	logic [MUL_W-1:0]   num, den, rem2;
	logic               prod_pos, ge;
	logic [RATIO_W:0]   sq_t;
	logic [SHIFT_W:0]   exp_p1;
	logic [SHIFT_W+FRAC_BITS:0] x_val;
	logic [SHIFT_W+FRAC_BITS+1:0] e_sum;
	logic [ENT_W-1:0]   ent;

	logic               out_valid_q, ratio_zero_q, no_samples_q;
	logic [ENT_W-1:0]   entropy_q;

	assign mul_a    = ctrl.do_sqr ? {1'b0, m_q} : {weight_one_total[SUM_W-1], weight_one_total};
	assign mul_b    = ctrl.do_sqr ? {1'b0, m_q} : {weight_two_total[SUM_W-1], weight_two_total};
	assign mul_full = mul_a * mul_b;

	assign k_pos    = kernel_total[SUM_W-1] ? '0 : kernel_total;
	assign num      = MUL_W'(k_pos) << NUM_SHIFT;
	assign prod_pos = !mul_q[MUL_W-1] && (mul_q != '0);
	assign den      = prod_pos ? mul_q : (MUL_W'(sample_tally) << DEN_SHIFT);

	// restoring divide step; rem stays below den < 2^63
	assign rem2 = {rem_q[MUL_W-2:0], 1'b0};
	assign ge   = rem2 >= den_q;

	// square truncated to Q2.31
	assign sq_t = mul_q[2*RATIO_W-1:RATIO_W-1];

	// -log2(r) = (shift + 1) - frac, Q.16; doubled and rounded to Q.9
	assign exp_p1 = (SHIFT_W+1)'(s_q) + (SHIFT_W+1)'(1);
	assign x_val  = {exp_p1, {FRAC_BITS{1'b0}}} - (SHIFT_W+FRAC_BITS+1)'(f_q);
	assign e_sum  = {x_val, 1'b0} + (SHIFT_W+FRAC_BITS+2)'(64);
	assign ent    = e_sum[SHIFT_W+FRAC_BITS+1:7];

	assign status.none   = (sample_tally == '0);
	assign status.sat    = (num >= den);
	assign status.m_top  = m_q[RATIO_W-1];
	assign status.m_zero = (m_q == '0);

	always_ff @(posedge clk) begin
		if (ctrl.do_prod || ctrl.do_sqr) mul_q <= mul_full[MUL_W-1:0];

		if (ctrl.do_setup) begin
			rem_q  <= num;
			den_q  <= den;
			m_q    <= status.sat ? '1 : '0;
			s_q    <= '0;
			f_q    <= '0;
			err_q  <= 1'b0;
			none_q <= status.none;
		end else if (ctrl.do_div) begin
			rem_q <= ge ? rem2 - den_q : rem2;
			m_q   <= {m_q[RATIO_W-2:0], ge};
		end else if (ctrl.do_norm) begin
			err_q <= status.m_zero;
			if (!status.m_top && !status.m_zero) begin
				m_q <= {m_q[RATIO_W-2:0], 1'b0};
				s_q <= s_q + SHIFT_W'(1);
			end
		end else if (ctrl.do_fold) begin
			if (sq_t[RATIO_W]) begin
				m_q <= sq_t[RATIO_W:1];
				f_q <= {f_q[FRAC_BITS-2:0], 1'b1};
			end else begin
				m_q <= sq_t[RATIO_W-1:0];
				f_q <= {f_q[FRAC_BITS-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load_out) begin
			entropy_q    <= (err_q || none_q) ? '0 : ent;
			ratio_zero_q <= err_q && !none_q;
			no_samples_q <= none_q;
		end
	end

	assign out_busy      = out_valid_q && !out_ready;
	assign out_valid     = out_valid_q;
	assign entropy_value = entropy_q;
	assign ratio_zero    = ratio_zero_q;
	assign no_samples    = no_samples_q;

endmodule

@@ rtl/kernel_density_entropy_accumulator_core.sv @@
`timescale 1ns / 1ps
// Kernel density entropy accumulator. Each accepted item may carry one sample
// (kernel value and two pixel weights, signed Q1.22); valid samples are summed
// into three 32-bit totals and counted, up to MAX_SAMPLES per pixel. An item
// with last set closes the pixel: the weight totals are multiplied (falling
// back to the sample count when that product is not positive), the clamped
// kernel total is divided by it into a Q0.32 ratio, and -log2(ratio^2) comes
// out as unsigned Q7.9 on entropy_value. no_samples marks an empty pixel,
// ratio_zero a zero ratio; entropy_value is zero in both cases. Sums clear as
// the result enters the output register.
// Sequencing: an item without last leaves in_ready high. An item with last
// holds in_ready low through product, setup, the bit-per-cycle restoring
// divider (skipped when the ratio saturates), the one-bit-per-cycle normalize
// shift, sixteen square-and-fold steps through the single shared 33x33
// multiplier (a square state, then a fold state, per step) and output load.
// An empty pixel goes from setup straight to output load; a zero ratio goes
// there from the first normalize step. The result waits in an output
// register; a stalled out_ready only delays the return to accumulation.
module kernel_density_entropy_accumulator_core #(
	parameter int MAX_SAMPLES = kdea_pkg::MAX_SAMPLES_DEF,
	parameter int INPUT_BITS  = kdea_pkg::INPUT_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic signed [INPUT_BITS-1:0] kernel_value,
	input  logic signed [INPUT_BITS-1:0] first_weight,
	input  logic signed [INPUT_BITS-1:0] second_weight,
	input  logic                         sample_valid,
	input  logic                         last,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [kdea_pkg::ENT_W-1:0]   entropy_value,
	output logic                         ratio_zero,
	output logic                         no_samples
);
	import kdea_pkg::*;

	localparam int TALLY_W = $clog2(MAX_SAMPLES + 1);

	logic               accept;
	ctrl_t              ctrl;
	status_t            status;
	logic               out_busy;
	logic [SUM_W-1:0]   kernel_total, weight_one_total, weight_two_total;
	logic [TALLY_W-1:0] sample_tally;

	assign accept = in_valid && in_ready;

	// running sums; the item carrying last is folded in before the math starts
	kdea_accum #(
		.MAX_SAMPLES (MAX_SAMPLES),
		.INPUT_BITS  (INPUT_BITS),
		.TALLY_W     (TALLY_W)
	) u_accum (
		.clk              (clk),
		.arst_n           (arst_n),
		.acc_en           (accept),
		.clr              (ctrl.load_out),
		.kernel_value     (kernel_value),
		.first_weight     (first_weight),
		.second_weight    (second_weight),
		.sample_valid     (sample_valid),
		.kernel_total     (kernel_total),
		.weight_one_total (weight_one_total),
		.weight_two_total (weight_two_total),
		.sample_tally     (sample_tally)
	);

	// sequencer: accumulate, product, setup, divide, normalize, square/fold, finish
	kdea_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.last     (last),
		.out_busy (out_busy),
		.status   (status),
		.in_ready (in_ready),
		.ctrl     (ctrl)
	);

	// shared multiplier, divider step, log2 fold and output register
	kdea_dpath #(
		.MAX_SAMPLES (MAX_SAMPLES),
		.TALLY_W     (TALLY_W)
	) u_dpath (
		.clk              (clk),
		.arst_n           (arst_n),
		.ctrl             (ctrl),
		.kernel_total     (kernel_total),
		.weight_one_total (weight_one_total),
		.weight_two_total (weight_two_total),
		.sample_tally     (sample_tally),
		.out_ready        (out_ready),
		.status           (status),
		.out_busy         (out_busy),
		.out_valid        (out_valid),
		.entropy_value    (entropy_value),
		.ratio_zero       (ratio_zero),
		.no_samples       (no_samples)
	);

endmodule

@@ rtl/kdea_chk.sv @@
`timescale 1ns / 1ps
module kdea_chk (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_ready,
	input logic                       last,
	input logic                       out_valid,
	input logic                       out_ready,
	input logic [kdea_pkg::ENT_W-1:0] entropy_value,
	input logic                       ratio_zero,
	input logic                       no_samples
);

	// a stalled result stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(entropy_value)
			&& $stable(ratio_zero) && $stable(no_samples))
		else $error("result changed or dropped while stalled");

	// closing a pixel always makes the block busy
	a_last_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && last |=> !in_ready)
		else $error("input taken right after a last item");

	// the two status flags exclude each other
	a_flags_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(ratio_zero && no_samples))
		else $error("ratio_zero and no_samples both set");

	// a flagged result carries zero entropy
	a_flag_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (ratio_zero || no_samples) |-> entropy_value == '0)
		else $error("flagged result with nonzero entropy");

endmodule

bind kernel_density_entropy_accumulator_core kdea_chk u_kdea_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_ready      (in_ready),
	.last          (last),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.entropy_value (entropy_value),
	.ratio_zero    (ratio_zero),
	.no_samples    (no_samples)
);
